FILE: design/ufr_pkg.sv
// Shared constants for the multi-format UART frame receiver.
// Used by the top level, including the sizing of its ufr_ram banks; depends on nothing.
package ufr_pkg;

  // Frame store size and the widths that follow from it.
  localparam int BUF_DEPTH  = 256;
  localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int ROW_W      = ADDR_W - 1;
  localparam int BANK_DEPTH = (BUF_DEPTH + 1) / 2;

  // Fixed field widths.
  localparam int BYTE_W = 8;
  localparam int RIDX_W = 8;
  localparam int FLEN_W = 9;
  localparam int EV_W   = 3;

  // Compare width wide enough for count + 2, read index and length + 2.
  localparam int CMP_W = (CNT_W + 1 > RIDX_W + 1) ? CNT_W + 1 : RIDX_W + 1;

  // Header bytes kept in flops.
  localparam int HDR_N  = 4;
  localparam int HDR_AW = 2;

  // Opcodes.
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Event codes.
  localparam logic [EV_W-1:0] EV_NONE        = 3'd0;
  localparam logic [EV_W-1:0] EV_LEN_DONE    = 3'd1;
  localparam logic [EV_W-1:0] EV_CUSTOM_DONE = 3'd2;
  localparam logic [EV_W-1:0] EV_BAD_HEADER  = 3'd3;
  localparam logic [EV_W-1:0] EV_B_WORD      = 3'd4;
  localparam logic [EV_W-1:0] EV_OVERFLOW    = 3'd5;
  localparam logic [EV_W-1:0] EV_BAD_BYTE    = 3'd6;

  // Mode bytes and framing characters.
  localparam logic [BYTE_W-1:0] MODE_IDLE   = 8'h00;
  localparam logic [BYTE_W-1:0] MODE_CUSTOM = 8'hC1;
  localparam logic [BYTE_W-1:0] MODE_LEN    = 8'h55;
  localparam logic [BYTE_W-1:0] MODE_B      = 8'h42;
  localparam logic [BYTE_W-1:0] HDR_BYTE1   = 8'hC2;
  localparam logic [BYTE_W-1:0] HDR_BYTE2   = 8'hC3;
  localparam logic [BYTE_W-1:0] HDR_BYTE3   = 8'hC4;
  localparam logic [BYTE_W-1:0] BYTE_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_U      = 8'h55;
  localparam logic [BYTE_W-1:0] CHAR_S      = 8'h53;
  localparam logic [BYTE_W-1:0] CHAR_Y      = 8'h59;

  // Length of a B-mode word.
  localparam int B_WORD_LEN = 4;

endpackage

FILE: design/ufr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module ufr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/uart_multi_format_frame_receiver_unit.sv
// Top level of the multi-format UART frame receiver.
// Depends on ufr_pkg and on ufr_ram for the two frame store banks.
// Latency: two register stages, stage one and the output register. Throughput:
// one transaction per cycle unless out_ready stalls the output; a deferred CR
// and the new byte are written in the same cycle, to opposite store banks.
// Reset clears the count, CR flag, header bytes, entry and stage valid bits.
module uart_multi_format_frame_receiver_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [ufr_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [ufr_pkg::RIDX_W-1:0]    read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ufr_pkg::EV_W-1:0]      event_res,
  output logic [ufr_pkg::FLEN_W-1:0]    frame_length,
  output logic [ufr_pkg::BYTE_W-1:0]    read_data
);
  import ufr_pkg::*;

  // Receive state: count, CR flag and the first store bytes in flops.
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic              cr_seen, cr_seen_next;
  logic [BYTE_W-1:0] hdr [HDR_N];
  logic [BYTE_W-1:0] hdr_next [HDR_N];
  logic [BUF_DEPTH-1:0] entry_vld;

  // Handshake.
  logic accept, s1_adv;
  logic s1_valid;

  // Per-transaction decode.
  logic [CMP_W-1:0]  n_x, n1_x, n2_x, depth_x, want_x, idx_x;
  logic [BYTE_W-1:0] len_byte;
  logic              w0_en, w1_en, w0_ok, w1_ok, w0_ram, w1_ram;
  logic [CMP_W-1:0]  w0_addr, w1_addr;
  logic [BYTE_W-1:0] w0_data;
  logic              clr0, clr1, set0, done, is_rx, hdr_ok;
  logic [EV_W-1:0]   ev;
  logic [CNT_W-1:0]  done_len, flen;

  // Bank ports.
  logic              bank_we [2];
  logic [ROW_W-1:0]  bank_waddr [2];
  logic [BYTE_W-1:0] bank_wdata [2];
  logic [BYTE_W-1:0] bank_rdata [2];
  logic              rd_issue, rd_in_range, rd_hdr;

  // Stage one registers.
  logic [EV_W-1:0]   s1_ev;
  logic [CNT_W-1:0]  s1_flen;
  logic              s1_rd, s1_hsel, s1_vld, s1_bank;
  logic [BYTE_W-1:0] s1_hval;
  logic [BYTE_W-1:0] s1_rdata;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign is_rx    = accept && (opcode == OP_RX);

  assign n_x     = CMP_W'(byte_count);
  assign n1_x    = n_x + CMP_W'(1);
  assign n2_x    = n_x + CMP_W'(2);
  assign depth_x = CMP_W'(BUF_DEPTH);
  assign hdr_ok  = (hdr[1] == HDR_BYTE1) && (hdr[2] == HDR_BYTE2) &&
                   (hdr[3] == HDR_BYTE3);

  // The length byte as it stands after this transaction's store write.
  assign len_byte = (byte_count == CNT_W'(1)) ? rx_byte : hdr[1];
  assign want_x   = CMP_W'(len_byte) + CMP_W'(2);

  // Frame decode: decide writes, restarts, count and event.
  always_comb begin
    w0_en           = 1'b0;
    w1_en           = 1'b0;
    w0_addr         = n_x;
    w1_addr         = n1_x;
    w0_data         = rx_byte;
    clr0            = 1'b0;
    clr1            = 1'b0;
    set0            = 1'b0;
    done            = 1'b0;
    done_len        = byte_count;
    ev              = EV_NONE;
    byte_count_next = byte_count;
    cr_seen_next    = cr_seen;
    if (is_rx) begin
      case (hdr[0])
        MODE_CUSTOM: begin
          if (cr_seen) begin
            if (rx_byte != BYTE_LF) begin
              // Held CR is stored as data, then the new byte.
              cr_seen_next = 1'b0;
              w0_en        = 1'b1;
              w0_data      = BYTE_CR;
              w1_en        = (n1_x < depth_x);
              if (n2_x >= depth_x) begin
                byte_count_next = '0;
                clr0            = 1'b1;
                ev              = EV_OVERFLOW;
              end else begin
                byte_count_next = CNT_W'(n2_x);
              end
            end else begin
              // CR LF ends the frame; the header decides the event.
              done            = 1'b1;
              done_len        = byte_count;
              byte_count_next = '0;
              cr_seen_next    = 1'b0;
              clr0            = 1'b1;
              ev              = hdr_ok ? EV_CUSTOM_DONE : EV_BAD_HEADER;
            end
          end else if (rx_byte == BYTE_CR) begin
            cr_seen_next = 1'b1;
          end else begin
            w0_en = 1'b1;
            if (n1_x >= depth_x) begin
              byte_count_next = '0;
              clr0            = 1'b1;
              ev              = EV_OVERFLOW;
            end else begin
              byte_count_next = CNT_W'(n1_x);
            end
          end
        end
        MODE_LEN: begin
          if (n_x >= depth_x) begin
            byte_count_next = '0;
            cr_seen_next    = 1'b0;
            clr0            = 1'b1;
            ev              = EV_OVERFLOW;
          end else begin
            w0_en = 1'b1;
            if (want_x == n1_x) begin
              done            = 1'b1;
              done_len        = CNT_W'(n1_x);
              byte_count_next = '0;
              cr_seen_next    = 1'b0;
              clr0            = 1'b1;
              ev              = EV_LEN_DONE;
            end else if (want_x < n1_x) begin
              // Overran the declared length: drop and clear the mode and length bytes.
              byte_count_next = '0;
              cr_seen_next    = 1'b0;
              clr0            = 1'b1;
              clr1            = 1'b1;
              ev              = EV_BAD_BYTE;
            end else begin
              byte_count_next = CNT_W'(n1_x);
            end
          end
        end
        MODE_B: begin
          if (!(rx_byte inside {CHAR_U, CHAR_S, CHAR_Y})) begin
            byte_count_next = CNT_W'(1);
            cr_seen_next    = 1'b0;
            clr1            = 1'b1;
            set0            = 1'b1;
            ev              = EV_BAD_BYTE;
          end else if (n_x >= depth_x) begin
            byte_count_next = '0;
            cr_seen_next    = 1'b0;
            clr0            = 1'b1;
            ev              = EV_OVERFLOW;
          end else begin
            w0_en = 1'b1;
            if (n1_x == CMP_W'(B_WORD_LEN)) begin
              byte_count_next = CNT_W'(n1_x);
              ev              = EV_B_WORD;
            end else if (n1_x > CMP_W'(B_WORD_LEN)) begin
              byte_count_next = CNT_W'(1);
              cr_seen_next    = 1'b0;
              clr1            = 1'b1;
              set0            = 1'b1;
              ev              = EV_BAD_BYTE;
            end else begin
              byte_count_next = CNT_W'(n1_x);
            end
          end
        end
        MODE_IDLE: begin
          byte_count_next = CNT_W'(1);
          cr_seen_next    = 1'b0;
          clr1            = 1'b1;
          set0            = 1'b1;
        end
        default: begin
          byte_count_next = CNT_W'(1);
          cr_seen_next    = 1'b0;
          clr1            = 1'b1;
          set0            = 1'b1;
          ev              = EV_BAD_BYTE;
        end
      endcase
    end
    flen = done ? done_len : byte_count_next;
  end

  // Route the writes: low entries to the header flops, the rest to the banks.
  assign w0_ok  = w0_en && (w0_addr < depth_x);
  assign w1_ok  = w1_en && (w1_addr < depth_x);
  assign w0_ram = w0_ok && (w0_addr >= CMP_W'(HDR_N));
  assign w1_ram = w1_ok && (w1_addr >= CMP_W'(HDR_N));

  always_comb begin
    for (int i = 0; i < HDR_N; i++) begin
      hdr_next[i] = hdr[i];
    end
    if (w0_ok && (w0_addr < CMP_W'(HDR_N))) begin
      hdr_next[w0_addr[HDR_AW-1:0]] = w0_data;
    end
    if (w1_ok && (w1_addr < CMP_W'(HDR_N))) begin
      hdr_next[w1_addr[HDR_AW-1:0]] = rx_byte;
    end
    // Restarts act after the store write of the same transaction.
    if (clr1) begin
      hdr_next[1] = '0;
    end
    if (clr0) begin
      hdr_next[0] = '0;
    end
    if (set0) begin
      hdr_next[0] = rx_byte;
    end
  end

  // Consecutive addresses fall in opposite banks, so both writes fit.
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      bank_we[b]    = 1'b0;
      bank_waddr[b] = w0_addr[ADDR_W-1:1];
      bank_wdata[b] = w0_data;
      if (w0_ram && (w0_addr[0] == 1'(b))) begin
        bank_we[b] = 1'b1;
      end else if (w1_ram && (w1_addr[0] == 1'(b))) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = w1_addr[ADDR_W-1:1];
        bank_wdata[b] = rx_byte;
      end
    end
  end

  // Read decode for the read opcode.
  assign idx_x       = CMP_W'(read_index);
  assign rd_in_range = idx_x < depth_x;
  assign rd_hdr      = idx_x < CMP_W'(HDR_N);
  assign rd_issue    = accept && (opcode == OP_READ) && rd_in_range && !rd_hdr;

  for (genvar g = 0; g < 2; g++) begin : g_bank
    ufr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wdata[g]),
      .re    (rd_issue && (idx_x[0] == 1'(g))),
      .raddr (idx_x[ADDR_W-1:1]),
      .rdata (bank_rdata[g])
    );
  end

  // Receive state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      cr_seen    <= 1'b0;
      for (int i = 0; i < HDR_N; i++) begin
        hdr[i] <= '0;
      end
    end else begin
      byte_count <= byte_count_next;
      cr_seen    <= cr_seen_next;
      for (int i = 0; i < HDR_N; i++) begin
        hdr[i] <= hdr_next[i];
      end
    end
  end

  // Entry valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else begin
      if (w0_ram) begin
        entry_vld[w0_addr[ADDR_W-1:0]] <= 1'b1;
      end
      if (w1_ram) begin
        entry_vld[w1_addr[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  // Stage one: waits for the bank read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ev   <= ev;
      s1_flen <= flen;
      s1_rd   <= (opcode == OP_READ) && rd_in_range;
      s1_hsel <= rd_hdr;
      s1_hval <= hdr[idx_x[HDR_AW-1:0]];
      s1_vld  <= entry_vld[idx_x[ADDR_W-1:0]];
      s1_bank <= idx_x[0];
    end
  end

  always_comb begin
    s1_rdata = '0;
    if (s1_rd) begin
      if (s1_hsel) begin
        s1_rdata = s1_hval;
      end else if (s1_vld) begin
        s1_rdata = bank_rdata[s1_bank];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      event_res    <= s1_ev;
      frame_length <= FLEN_W'(s1_flen);
      read_data    <= s1_rdata;
    end
  end

endmodule
